// ----- hdl/cv3_pkg.sv -----
// shared types and constants for the 3x3 convolution unit
// no dependencies
package cv3_pkg;

  localparam int KERNEL_SIZE    = 3;
  localparam int COEF_FRAC_BITS = 8;
  localparam int PIX_W          = 8;
  localparam int COEF_W         = 16;
  localparam int ROW_W          = 48;
  localparam int PROD_W         = 25;
  localparam int SUM_W          = 29;
  localparam int CHAN_W         = 2;
  localparam int GEOM_W         = 12;
  localparam int COUNT_W        = 3;
  localparam int ROW_POS_W      = 13;
  localparam int INDEX_W        = 3;

  typedef enum logic [INDEX_W-1:0] {
    REG_COEF_TOP,
    REG_COEF_MID,
    REG_COEF_BOT,
    REG_FRAME_WIDTH,
    REG_FRAME_HEIGHT,
    REG_CHANNEL_COUNT
  } reg_index_t;

  localparam logic [ROW_W-1:0]   COEF_TOP_RESET   = 48'h0;
  localparam logic [ROW_W-1:0]   COEF_MID_RESET   = 48'h0000_0100_0000;
  localparam logic [ROW_W-1:0]   COEF_BOT_RESET   = 48'h0;
  localparam logic [GEOM_W-1:0]  WIDTH_RESET      = 12'd640;
  localparam logic [GEOM_W-1:0]  HEIGHT_RESET     = 12'd480;
  localparam logic [COUNT_W-1:0] CHANNELS_RESET   = 3'd1;

  typedef logic [KERNEL_SIZE-1:0][KERNEL_SIZE-1:0][PIX_W-1:0] window_t;
  typedef logic [KERNEL_SIZE-1:0][PIX_W-1:0] column_t;

  typedef struct packed {
    logic              en;
    logic              clear;
    logic              left_edge;
    logic [CHAN_W-1:0] chan;
  } tap_ctrl_t;

endpackage

// ----- hdl/cv3_line_buf.sv -----
// two line buffers with registered read and same-address write bypass
// depends on cv3_pkg
module cv3_line_buf
  import cv3_pkg::*;
#(
  parameter int DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [PIX_W-1:0]         wr_above,
  input  logic [PIX_W-1:0]         wr_mid,
  output logic [PIX_W-1:0]         rd_above,
  output logic [PIX_W-1:0]         rd_mid
);

  logic [PIX_W-1:0] mem_above [DEPTH];
  logic [PIX_W-1:0] mem_mid [DEPTH];
  logic [PIX_W-1:0] raw_above;
  logic [PIX_W-1:0] raw_mid;
  logic [PIX_W-1:0] byp_above;
  logic [PIX_W-1:0] byp_mid;
  logic             bypass;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_above[wr_addr] <= wr_above;
      mem_mid[wr_addr]   <= wr_mid;
    end
    if (rd_en) begin
      raw_above <= mem_above[rd_addr];
      raw_mid   <= mem_mid[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bypass <= 1'b0;
    end else if (rd_en) begin
      bypass <= wr_en && (wr_addr == rd_addr);
    end
    if (rd_en) begin
      byp_above <= wr_above;
      byp_mid   <= wr_mid;
    end
  end

  assign rd_above = bypass ? byp_above : raw_above;
  assign rd_mid   = bypass ? byp_mid : raw_mid;

endmodule

// ----- hdl/cv3_window.sv -----
// per-channel 3x3 tap window, shift and right-edge padding
// depends on cv3_pkg
module cv3_window
  import cv3_pkg::*;
#(
  parameter int MAX_CHANNELS = 4
) (
  input  logic      clk,
  input  logic      rst,
  input  tap_ctrl_t ctrl,
  input  column_t   col,
  output window_t   win
);

  localparam int CH_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

  window_t          taps [MAX_CHANNELS];
  window_t          cur;
  window_t          shifted;
  window_t          restarted;
  window_t          padded;
  logic [CH_W-1:0]  sel;

  assign sel = ctrl.chan[CH_W-1:0];
  assign cur = taps[sel];

  always_comb begin
    for (int r = 0; r < KERNEL_SIZE; r++) begin
      shifted[r][0]   = cur[r][1];
      shifted[r][1]   = cur[r][2];
      shifted[r][2]   = col[r];
      restarted[r][0] = '0;
      restarted[r][1] = '0;
      restarted[r][2] = col[r];
      padded[r][0]    = cur[r][1];
      padded[r][1]    = cur[r][2];
      padded[r][2]    = '0;
    end
  end

  assign win = ctrl.left_edge ? padded : shifted;

  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      for (int c = 0; c < MAX_CHANNELS; c++) begin
        taps[c] <= '0;
      end
    end else if (ctrl.en) begin
      taps[sel] <= ctrl.left_edge ? restarted : shifted;
    end
  end

endmodule

// ----- hdl/cv3_mac.sv -----
// nine-tap multiply-accumulate, floor, clamp to 0..255, result register
// depends on cv3_pkg
module cv3_mac
  import cv3_pkg::*;
(
  input  logic             clk,
  input  logic             load,
  input  window_t          win,
  input  logic             last_in,
  input  logic [ROW_W-1:0] coef_top,
  input  logic [ROW_W-1:0] coef_mid,
  input  logic [ROW_W-1:0] coef_bot,
  output logic [PIX_W-1:0] filtered,
  output logic             frame_last
);

  logic signed [SUM_W-1:0] sum;
  logic signed [SUM_W-1:0] quot;
  logic [PIX_W-1:0]        clamped;

  always_comb begin
    logic [ROW_W-1:0]         rows [KERNEL_SIZE];
    logic signed [PROD_W-1:0] prod;
    rows[0] = coef_top;
    rows[1] = coef_mid;
    rows[2] = coef_bot;
    sum = '0;
    for (int r = 0; r < KERNEL_SIZE; r++) begin
      for (int k = 0; k < KERNEL_SIZE; k++) begin
        prod = $signed({1'b0, win[r][k]}) * $signed(rows[r][COEF_W*k +: COEF_W]);
        sum  = sum + SUM_W'(prod);
      end
    end
  end

  assign quot = sum >>> COEF_FRAC_BITS;

  always_comb begin
    if (sum[SUM_W-1]) begin
      clamped = '0;
    end else if (|quot[SUM_W-1:PIX_W]) begin
      clamped = '1;
    end else begin
      clamped = quot[PIX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      filtered   <= clamped;
      frame_last <= last_in;
    end
  end

endmodule

// ----- hdl/conv3x3_zero_pad_saturate_unit.sv -----
// 3x3 convolution with zero padding and saturation, top level
// depends on cv3_pkg, cv3_line_buf, cv3_window, cv3_mac
// pipeline: request in s1, its window in s2, the kernel result in the output register
// throughput: one request per cycle unless out_ready stalls; line buffers: 1R1W each
// reset: rst (synchronous) restores register defaults, positions, taps, valids
// line buffers are not cleared; entries are only used after they were written
module conv3x3_zero_pad_saturate_unit
  import cv3_pkg::*;
#(
  parameter int MAX_LINE_SAMPLES = 8192,
  parameter int MAX_CHANNELS     = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [INDEX_W-1:0] cfg_index,
  input  logic [ROW_W-1:0]   cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [PIX_W-1:0]   sample,
  input  logic               drain,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [PIX_W-1:0]   filtered,
  output logic               frame_last
);

  localparam int ADDR_W = $clog2(MAX_LINE_SAMPLES);

  typedef struct packed {
    logic              pad;
    logic [PIX_W-1:0]  sample;
    logic              left_edge;
    logic              row_ge1;
    logic              row_ge2;
    logic              emit;
    logic              last;
    logic [CHAN_W-1:0] chan;
  } item_t;

  logic [ROW_W-1:0]     coef_top;
  logic [ROW_W-1:0]     coef_mid;
  logic [ROW_W-1:0]     coef_bot;
  logic [GEOM_W-1:0]    frame_width;
  logic [GEOM_W-1:0]    frame_height;
  logic [COUNT_W-1:0]   channel_count;

  logic [GEOM_W-1:0]    col_pos;
  logic [ROW_POS_W-1:0] row_pos;
  logic [CHAN_W-1:0]    chan;
  logic [ADDR_W-1:0]    line_addr;

  logic [GEOM_W-1:0]    w_eff;
  logic [GEOM_W-1:0]    h_eff;
  logic [COUNT_W-1:0]   ch_eff;
  logic [ROW_POS_W-1:0] h_ext;
  logic [ROW_POS_W-1:0] h_plus1;
  logic                 geom_write;
  logic                 accept;
  logic                 chan_wrap;
  logic                 col_wrap;
  logic                 row_wrap;
  item_t                item0;

  logic                 s1_valid;
  item_t                s1;
  logic [ADDR_W-1:0]    s1_addr;
  logic                 s1_free;
  logic                 s1_move;
  logic                 s2_valid;
  window_t              s2_win;
  logic                 s2_last;
  logic                 s2_free;
  logic                 out_free;

  logic [PIX_W-1:0]     rd_above;
  logic [PIX_W-1:0]     rd_mid;
  column_t              col;
  window_t              win;
  tap_ctrl_t            tap_ctrl;

  // configuration
  assign geom_write = cfg_write && (cfg_index == REG_FRAME_WIDTH ||
                                    cfg_index == REG_FRAME_HEIGHT ||
                                    cfg_index == REG_CHANNEL_COUNT);

  always_ff @(posedge clk) begin
    if (rst) begin
      coef_top      <= COEF_TOP_RESET;
      coef_mid      <= COEF_MID_RESET;
      coef_bot      <= COEF_BOT_RESET;
      frame_width   <= WIDTH_RESET;
      frame_height  <= HEIGHT_RESET;
      channel_count <= CHANNELS_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_COEF_TOP:      coef_top      <= cfg_data;
        REG_COEF_MID:      coef_mid      <= cfg_data;
        REG_COEF_BOT:      coef_bot      <= cfg_data;
        REG_FRAME_WIDTH:   frame_width   <= cfg_data[GEOM_W-1:0];
        REG_FRAME_HEIGHT:  frame_height  <= cfg_data[GEOM_W-1:0];
        REG_CHANNEL_COUNT: channel_count <= cfg_data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // effective geometry
  always_comb begin
    w_eff = (frame_width == '0) ? GEOM_W'(1) : frame_width;
    h_eff = (frame_height == '0) ? GEOM_W'(1) : frame_height;
    if (channel_count == '0) begin
      ch_eff = COUNT_W'(1);
    end else if (channel_count > COUNT_W'(MAX_CHANNELS)) begin
      ch_eff = COUNT_W'(MAX_CHANNELS);
    end else begin
      ch_eff = channel_count;
    end
  end

  assign h_ext   = {1'b0, h_eff};
  assign h_plus1 = h_ext + ROW_POS_W'(1);

  // request decode from the current position
  assign accept    = in_valid && in_ready;
  assign chan_wrap = ({1'b0, chan} + COUNT_W'(1)) >= ch_eff;
  assign col_wrap  = ({1'b0, col_pos} + ROW_POS_W'(1)) >= {1'b0, w_eff};
  assign row_wrap  = row_pos >= h_plus1;

  always_comb begin
    item0.pad       = drain || (row_pos >= h_ext);
    item0.sample    = sample;
    item0.left_edge = (col_pos == '0);
    item0.row_ge1   = (row_pos != '0);
    item0.row_ge2   = (row_pos >= ROW_POS_W'(2));
    item0.emit      = item0.left_edge ? item0.row_ge2
                                      : (item0.row_ge1 && (row_pos <= h_ext));
    item0.last      = item0.left_edge && item0.row_ge2 && row_wrap && chan_wrap;
    item0.chan      = chan;
  end

  // position counters
  always_ff @(posedge clk) begin
    if (rst || geom_write) begin
      col_pos   <= '0;
      row_pos   <= '0;
      chan      <= '0;
      line_addr <= '0;
    end else if (accept) begin
      if (item0.last) begin
        col_pos   <= '0;
        row_pos   <= '0;
        chan      <= '0;
        line_addr <= '0;
      end else begin
        if (chan_wrap) begin
          chan <= '0;
          if (col_wrap) begin
            col_pos <= '0;
            row_pos <= row_wrap ? '0 : row_pos + ROW_POS_W'(1);
          end else begin
            col_pos <= col_pos + GEOM_W'(1);
          end
        end else begin
          chan <= chan + CHAN_W'(1);
        end
        if (chan_wrap && col_wrap) begin
          line_addr <= '0;
        end else if (line_addr == ADDR_W'(MAX_LINE_SAMPLES - 1)) begin
          line_addr <= '0;
        end else begin
          line_addr <= line_addr + ADDR_W'(1);
        end
      end
    end
  end

  // pipeline flow
  assign out_free = !out_valid || out_ready;
  assign s2_free  = !s2_valid || out_free;
  assign s1_free  = !s1_valid || s2_free;
  assign s1_move  = s1_valid && s2_free;
  assign in_ready = s1_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s1_free) begin
        s1_valid <= accept;
      end
      if (s2_free) begin
        s2_valid <= s1_move && s1.emit;
      end
      if (out_free) begin
        out_valid <= s2_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1      <= item0;
      s1_addr <= line_addr;
    end
    if (s2_free) begin
      s2_win  <= win;
      s2_last <= s1.last;
    end
  end

  // column of new samples
  assign col[0] = s1.row_ge2 ? rd_above : '0;
  assign col[1] = s1.row_ge1 ? rd_mid : '0;
  assign col[2] = s1.pad ? '0 : s1.sample;

  cv3_line_buf #(
    .DEPTH (MAX_LINE_SAMPLES)
  ) u_line_buf (
    .clk      (clk),
    .rst      (rst),
    .rd_en    (accept),
    .rd_addr  (line_addr),
    .wr_en    (s1_move),
    .wr_addr  (s1_addr),
    .wr_above (col[1]),
    .wr_mid   (col[2]),
    .rd_above (rd_above),
    .rd_mid   (rd_mid)
  );

  always_comb begin
    tap_ctrl.en        = s1_move;
    tap_ctrl.clear     = geom_write || (s1_move && s1.last);
    tap_ctrl.left_edge = s1.left_edge;
    tap_ctrl.chan      = s1.chan;
  end

  cv3_window #(
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_window (
    .clk  (clk),
    .rst  (rst),
    .ctrl (tap_ctrl),
    .col  (col),
    .win  (win)
  );

  cv3_mac u_mac (
    .clk        (clk),
    .load       (out_free && s2_valid),
    .win        (s2_win),
    .last_in    (s2_last),
    .coef_top   (coef_top),
    .coef_mid   (coef_mid),
    .coef_bot   (coef_bot),
    .filtered   (filtered),
    .frame_last (frame_last)
  );

  // checks
  a_restart_on_last: assert property (@(posedge clk) disable iff (rst)
    accept && item0.last && !geom_write |=> col_pos == '0 && row_pos == '0 && chan == '0)
    else $error("position not cleared after frame end");

  a_col_in_range: assert property (@(posedge clk) disable iff (rst)
    col_pos < w_eff)
    else $error("column position beyond frame width");

  a_row_in_range: assert property (@(posedge clk) disable iff (rst)
    row_pos <= h_plus1)
    else $error("row position beyond drain rows");

  a_chan_in_range: assert property (@(posedge clk) disable iff (rst)
    {1'b0, chan} < ch_eff)
    else $error("channel position beyond channel count");

  a_addr_in_range: assert property (@(posedge clk) disable iff (rst)
    line_addr <= ADDR_W'(MAX_LINE_SAMPLES - 1))
    else $error("line buffer address beyond depth");

endmodule

// ----- test/tb.sv -----
// self-checking bench for conv3x3_zero_pad_saturate_unit: random and directed pixel streams
// are checked against an in-bench model of the line buffers, taps and saturating kernel sum
// depends on cv3_pkg and the unit's rtl
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import cv3_pkg::*;

  localparam int LINE_DEPTH = 8192;
  localparam int MAX_CHANNELS = 4;
  localparam int PIX_MAX = 2**PIX_W - 1;
  localparam int SETTLE_CYCLES = 8;
  localparam int RESET_PROBE_ITEMS = 680;
  localparam int EXTREME_ITEMS = 40;
  localparam int RANDOM_ITEMS = 320;
  localparam int LONG_HOLD = 200;
  localparam int END_WAIT_LIMIT = 100000;
  localparam int PRINT_LIMIT = 30;
  localparam longint RUN_LIMIT_NS = 10_000_000;
  localparam logic [INDEX_W-1:0] REG_UNMAPPED_LO = 3'd6;
  localparam logic [INDEX_W-1:0] REG_UNMAPPED_HI = 3'd7;

  typedef struct packed {
    logic [PIX_W-1:0] value;
    logic             last;
  } pixel_result_t;

  logic               clk = 1'b0;
  logic               rst;
  logic               cfg_write;
  logic [INDEX_W-1:0] cfg_index;
  logic [ROW_W-1:0]   cfg_data;
  logic               in_valid;
  logic               in_ready;
  logic [PIX_W-1:0]   sample;
  logic               drain;
  logic               out_valid;
  logic               out_ready;
  logic [PIX_W-1:0]   filtered;
  logic               frame_last;

  // bench copy of the unit's registers and state
  logic [ROW_W-1:0]   kernel_rows [KERNEL_SIZE];
  logic [GEOM_W-1:0]  width_cfg;
  logic [GEOM_W-1:0]  height_cfg;
  logic [COUNT_W-1:0] chans_cfg;
  logic [PIX_W-1:0]   line_two_up [LINE_DEPTH];
  logic [PIX_W-1:0]   line_one_up [LINE_DEPTH];
  window_t            tap_grid [MAX_CHANNELS];
  int unsigned        next_col;
  int unsigned        next_row;
  int unsigned        next_chan;

  pixel_result_t expected_pixels [$];
  pixel_result_t want;
  int unsigned   error_count;
  int unsigned   item_count;
  bit            ready_always;
  bit            sender_gapless;
  int unsigned   hold_request;

  conv3x3_zero_pad_saturate_unit dut (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .sample(sample),
    .drain(drain),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .filtered(filtered),
    .frame_last(frame_last)
  );

  always #2 clk = ~clk;

  function automatic int unsigned eff_width();
    return (width_cfg == 0) ? 1 : width_cfg;
  endfunction

  function automatic int unsigned eff_height();
    return (height_cfg == 0) ? 1 : height_cfg;
  endfunction

  function automatic int unsigned eff_channels();
    if (chans_cfg == 0) return 1;
    return (chans_cfg > MAX_CHANNELS) ? MAX_CHANNELS : chans_cfg;
  endfunction

  function automatic int unsigned frame_items();
    return eff_width() * eff_channels() * (eff_height() + 1) + eff_channels();
  endfunction

  function automatic logic [INDEX_W-1:0] coef_reg(input int unsigned row);
    case (row)
      0: return REG_COEF_TOP;
      1: return REG_COEF_MID;
      default: return REG_COEF_BOT;
    endcase
  endfunction

  function automatic logic [ROW_W-1:0] pick_kernel_row();
    logic [ROW_W-1:0] row;
    int unsigned k;
    row = ROW_W'({$urandom, $urandom});
    for (k = 0; k < KERNEL_SIZE; k++) begin
      case ($urandom_range(0, 7))
        0: row[COEF_W*k +: COEF_W] = 16'h7FFF;
        1: row[COEF_W*k +: COEF_W] = 16'h8000;
        2: row[COEF_W*k +: COEF_W] = '0;
        3: ;
        default: row[COEF_W*k +: COEF_W] = COEF_W'($urandom_range(0, 256) - 128);
      endcase
    end
    return row;
  endfunction

  function automatic logic [PIX_W-1:0] apply_kernel(input window_t win);
    longint acc;
    int r, k;
    acc = 0;
    for (r = 0; r < KERNEL_SIZE; r++)
      for (k = 0; k < KERNEL_SIZE; k++)
        acc += $signed({1'b0, win[r][k]}) * $signed(kernel_rows[r][COEF_W*k +: COEF_W]);
    if (acc < 0) return '0;
    acc = acc >>> COEF_FRAC_BITS;
    return (acc > PIX_MAX) ? PIX_W'(PIX_MAX) : acc[PIX_W-1:0];
  endfunction

  task automatic restart_positions();
    int c;
    next_col = 0;
    next_row = 0;
    next_chan = 0;
    for (c = 0; c < MAX_CHANNELS; c++) tap_grid[c] = '0;
  endtask

  // one accepted request: update lines and taps, queue the result it completes
  task automatic advance_filter(input logic [PIX_W-1:0] s, input logic d);
    int unsigned w, h, ch, x, y, c, addr, r;
    column_t fresh;
    window_t win;
    bit pad, emit, last;
    pixel_result_t res;
    w = eff_width();
    h = eff_height();
    ch = eff_channels();
    x = next_col;
    y = next_row;
    c = next_chan;
    if (c >= ch) c = ch - 1;
    pad = d || (y >= h);
    fresh[2] = pad ? '0 : s;
    addr = (x * ch + c) % LINE_DEPTH;
    fresh[0] = (y >= 2) ? line_two_up[addr] : '0;
    fresh[1] = (y >= 1) ? line_one_up[addr] : '0;
    line_two_up[addr] = fresh[1];
    line_one_up[addr] = fresh[2];
    emit = 0;
    last = 0;
    win = '0;
    if (x >= 1) begin
      for (r = 0; r < KERNEL_SIZE; r++) begin
        tap_grid[c][r][0] = tap_grid[c][r][1];
        tap_grid[c][r][1] = tap_grid[c][r][2];
        tap_grid[c][r][2] = fresh[r];
      end
      if (y >= 1 && y <= h) begin
        win = tap_grid[c];
        emit = 1;
      end
    end else begin
      // right edge pixel of the row above: right column is padding
      for (r = 0; r < KERNEL_SIZE; r++) begin
        win[r][0] = tap_grid[c][r][1];
        win[r][1] = tap_grid[c][r][2];
        win[r][2] = '0;
      end
      if (y >= 2) begin
        emit = 1;
        last = (y >= h + 1) && (c + 1 >= ch);
      end
      for (r = 0; r < KERNEL_SIZE; r++) begin
        tap_grid[c][r] = '0;
        tap_grid[c][r][2] = fresh[r];
      end
    end
    if (emit) begin
      res.value = apply_kernel(win);
      res.last = last;
      expected_pixels.push_back(res);
    end
    if (last) begin
      restart_positions();
    end else begin
      c++;
      if (c >= ch) begin
        c = 0;
        x++;
        if (x >= w) begin
          x = 0;
          y++;
          if (y > h + 1) y = 0;
        end
      end
      next_col = x;
      next_row = y;
      next_chan = c;
    end
  endtask

  task automatic report_mismatch(input string what);
    error_count++;
    if (error_count <= PRINT_LIMIT) $display("[%0t] mismatch: %s", $realtime, what);
  endtask

  task automatic write_reg(input logic [INDEX_W-1:0] idx, input logic [ROW_W-1:0] data);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    @(negedge clk);
    cfg_write = 1'b0;
    case (idx)
      REG_COEF_TOP: kernel_rows[0] = data;
      REG_COEF_MID: kernel_rows[1] = data;
      REG_COEF_BOT: kernel_rows[2] = data;
      REG_FRAME_WIDTH: begin
        width_cfg = data[GEOM_W-1:0];
        restart_positions();
      end
      REG_FRAME_HEIGHT: begin
        height_cfg = data[GEOM_W-1:0];
        restart_positions();
      end
      REG_CHANNEL_COUNT: begin
        chans_cfg = data[COUNT_W-1:0];
        restart_positions();
      end
      default: ;
    endcase
  endtask

  // upper data bits carry junk that the unit must ignore
  task automatic set_geometry(input int unsigned w, input int unsigned h, input int unsigned ch);
    logic [ROW_W-1:0] data;
    data = ROW_W'({$urandom, $urandom});
    data[GEOM_W-1:0] = GEOM_W'(w);
    write_reg(REG_FRAME_WIDTH, data);
    data = ROW_W'({$urandom, $urandom});
    data[GEOM_W-1:0] = GEOM_W'(h);
    write_reg(REG_FRAME_HEIGHT, data);
    data = ROW_W'({$urandom, $urandom});
    data[COUNT_W-1:0] = COUNT_W'(ch);
    write_reg(REG_CHANNEL_COUNT, data);
  endtask

  task automatic wait_idle();
    while (expected_pixels.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic send_item(input logic [PIX_W-1:0] s, input logic d);
    int unsigned gap, roll;
    in_valid = 1'b1;
    sample = s;
    drain = d;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    advance_filter(s, d);
    item_count++;
    @(negedge clk);
    gap = 0;
    if (!sender_gapless) begin
      roll = $urandom_range(0, 99);
      if (roll >= 97) gap = $urandom_range(20, 50);
      else if (roll >= 85) gap = $urandom_range(4, 10);
      else if (roll >= 55) gap = $urandom_range(1, 3);
    end
    if (gap != 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // frame from the current position; stop_after cuts it short, pause_at waits for
  // every result mid-frame and swaps one kernel row, fill < 0 means random pixels
  task automatic stream_frame(input int unsigned stop_after, input int unsigned pause_at,
                              input bit noisy, input int fill);
    int unsigned total, n;
    logic [PIX_W-1:0] s;
    logic d;
    total = frame_items();
    if (stop_after != 0 && stop_after < total) total = stop_after;
    for (n = 0; n < total; n++) begin
      if (pause_at != 0 && n == pause_at) begin
        in_valid = 1'b0;
        wait_idle();
        write_reg(coef_reg($urandom_range(0, 2)), pick_kernel_row());
      end
      case ($urandom_range(0, 9))
        0: s = '0;
        1: s = PIX_W'(PIX_MAX);
        default: s = PIX_W'($urandom_range(0, PIX_MAX));
      endcase
      if (fill >= 0) s = fill[PIX_W-1:0];
      if (next_row < eff_height()) begin
        d = noisy && ($urandom_range(0, 15) == 0);
      end else begin
        // past the last row: padding whatever the drain bit says
        d = noisy ? 1'($urandom_range(0, 1)) : 1'b1;
        if (!noisy && fill < 0) s = '0;
      end
      send_item(s, d);
    end
    in_valid = 1'b0;
    wait_idle();
  endtask

  task automatic test_reset_defaults();
    // identity kernel, 640 wide: the start of the first row comes back unchanged
    stream_frame(RESET_PROBE_ITEMS, 0, 0, -1);
  endtask

  task automatic test_directed_cases();
    set_geometry(2, 1, 1);
    write_reg(REG_COEF_TOP, {3{16'h7FFF}});
    write_reg(REG_COEF_MID, {3{16'h7FFF}});
    write_reg(REG_COEF_BOT, {3{16'h7FFF}});
    stream_frame(0, 0, 0, PIX_MAX);
    write_reg(REG_COEF_TOP, {3{16'h8000}});
    write_reg(REG_COEF_MID, {3{16'h8000}});
    write_reg(REG_COEF_BOT, {3{16'h8000}});
    stream_frame(0, 0, 0, PIX_MAX);
    write_reg(REG_COEF_TOP, COEF_TOP_RESET);
    write_reg(REG_COEF_MID, COEF_MID_RESET);
    write_reg(REG_COEF_BOT, COEF_BOT_RESET);
    // zero geometry acts as one
    set_geometry(0, 0, 0);
    stream_frame(0, 0, 1, -1);
    write_reg(REG_UNMAPPED_LO, ROW_W'({$urandom, $urandom}));
    write_reg(REG_UNMAPPED_HI, ROW_W'({$urandom, $urandom}));
    // channel count above four acts as four
    set_geometry(1, 1, 7);
    stream_frame(0, 0, 1, -1);
  endtask

  task automatic test_midframe_pause();
    set_geometry(5, 3, 3);
    write_reg(REG_COEF_MID, pick_kernel_row());
    stream_frame(0, 23, 0, -1);
  endtask

  task automatic test_output_stall();
    set_geometry(8, 4, 2);
    sender_gapless = 1;
    hold_request = LONG_HOLD;
    stream_frame(0, 0, 0, -1);
    sender_gapless = 0;
  endtask

  task automatic test_geometry_extremes();
    int unsigned k;
    sender_gapless = 1;
    ready_always = 1;
    for (k = 0; k < KERNEL_SIZE; k++) write_reg(coef_reg(k), pick_kernel_row());
    // widest and tallest frames, cut short and restarted by the next geometry write
    set_geometry(4095, 1, 7);
    stream_frame(EXTREME_ITEMS, 0, 0, -1);
    set_geometry(1, 4095, 1);
    stream_frame(EXTREME_ITEMS, 0, 1, -1);
    sender_gapless = 0;
    ready_always = 0;
  endtask

  task automatic test_random_frames();
    int unsigned goal, w, h, ch, k;
    bit restart_owed;
    goal = item_count + RANDOM_ITEMS;
    restart_owed = 1;
    while (item_count < goal) begin
      ready_always = ($urandom_range(0, 7) == 0);
      sender_gapless = ($urandom_range(0, 7) == 0);
      if (restart_owed || $urandom_range(0, 2) != 0) begin
        k = $urandom_range(0, 19);
        w = (k == 0) ? 0 : (k < 3) ? $urandom_range(7, 12) : $urandom_range(1, 6);
        k = $urandom_range(0, 19);
        h = (k == 0) ? 0 : (k < 3) ? $urandom_range(6, 8) : $urandom_range(1, 5);
        k = $urandom_range(0, 19);
        ch = (k < 2) ? 0 : (k < 4) ? $urandom_range(5, 7) : $urandom_range(1, 4);
        set_geometry(w, h, ch);
        restart_owed = 0;
      end
      for (k = 0; k < KERNEL_SIZE; k++)
        if ($urandom_range(0, 2) == 0) write_reg(coef_reg(k), pick_kernel_row());
      case ($urandom_range(0, 9))
        0: begin
          // broken frame, cleared by the next geometry write
          stream_frame($urandom_range(1, frame_items()), 0, 1, -1);
          restart_owed = 1;
        end
        1: stream_frame(0, 0, 1, -1);
        2: stream_frame(0, $urandom_range(1, frame_items() - 1), 0, -1);
        default: stream_frame(0, 0, 0, -1);
      endcase
    end
    ready_always = 0;
    sender_gapless = 0;
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_pixels.size() == 0) begin
        report_mismatch($sformatf("unexpected result %0d", filtered));
      end else begin
        want = expected_pixels.pop_front();
        if (filtered !== want.value)
          report_mismatch($sformatf("filtered %0d, wanted %0d", filtered, want.value));
        if (frame_last !== want.last)
          report_mismatch($sformatf("frame_last %0b, wanted %0b", frame_last, want.last));
      end
    end
  end

  initial begin : receiver
    int unsigned stall, roll;
    stall = 0;
    out_ready = 1'b1;
    forever begin
      @(negedge clk);
      if (hold_request != 0) begin
        stall = hold_request;
        hold_request = 0;
      end
      if (stall != 0) begin
        out_ready = 1'b0;
        stall--;
      end else if (ready_always) begin
        out_ready = 1'b1;
      end else begin
        roll = $urandom_range(0, 99);
        out_ready = (roll < 70);
        if (roll >= 97) stall = $urandom_range(10, 40);
        else if (roll >= 70) stall = $urandom_range(0, 2);
      end
    end
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    int unsigned guard;
    cfg_write = 1'b0;
    cfg_index = REG_COEF_TOP;
    cfg_data = '0;
    in_valid = 1'b0;
    sample = '0;
    drain = 1'b0;
    error_count = 0;
    item_count = 0;
    ready_always = 0;
    sender_gapless = 0;
    hold_request = 0;
    kernel_rows[0] = COEF_TOP_RESET;
    kernel_rows[1] = COEF_MID_RESET;
    kernel_rows[2] = COEF_BOT_RESET;
    width_cfg = WIDTH_RESET;
    height_cfg = HEIGHT_RESET;
    chans_cfg = CHANNELS_RESET;
    for (guard = 0; guard < LINE_DEPTH; guard++) begin
      line_two_up[guard] = '0;
      line_one_up[guard] = '0;
    end
    restart_positions();
    rst = 1'b1;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_reset_defaults();
    test_directed_cases();
    test_midframe_pause();
    test_output_stall();
    test_geometry_extremes();
    test_random_frames();

    guard = 0;
    while (expected_pixels.size() != 0 && guard < END_WAIT_LIMIT) begin
      @(negedge clk);
      guard++;
    end
    repeat (2 * SETTLE_CYCLES) @(negedge clk);
    if (expected_pixels.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_pixels.size()));
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
